@@ rtl/core/gdd_pkg.sv @@
package gdd_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned DIST_W  = 22;
    // Day count from the start of year 0; holds 16383 years plus a day of year
    localparam int unsigned EPOCH_W = 23;
    localparam int unsigned MLEN_W  = 5;

    localparam int unsigned DEFAULT_MAX_YEAR = 9999;
    localparam int unsigned MAX_YEAR_W       = 16;

    // Quotient by 100 of a year: (y * 5243) >> 19 is exact for y below 43699
    localparam int unsigned RECIP_100   = 5243;
    localparam int unsigned RECIP_W     = 13;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned PROD_W      = YEAR_W + RECIP_W;
    localparam int unsigned Q_W         = PROD_W - RECIP_SHIFT;
    localparam int unsigned CENT_W      = Q_W + 7;

    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned DAYS_PER_CENT = 100;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [EPOCH_W-1:0] epoch_t;
    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [Q_W-1:0]     quot_t;
    typedef logic [MLEN_W-1:0]  mlen_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SECOND,
        ST_RESULT
    } top_state_t;

    typedef enum logic [2:0] {
        EU_IDLE,
        EU_QYEAR,
        EU_QPREV,
        EU_BASE,
        EU_MONTH
    } eu_state_t;

    typedef enum logic [MONTH_W-1:0] {
        MON_JAN = 4'd1,
        MON_FEB = 4'd2,
        MON_MAR = 4'd3,
        MON_MAY = 4'd5,
        MON_JUL = 4'd7,
        MON_AUG = 4'd8,
        MON_OCT = 4'd10,
        MON_DEC = 4'd12
    } month_code_t;

    function automatic mlen_t month_length(input month_t m, input logic leap);
        mlen_t len;
        len = mlen_t'(30);
        if (m == MON_JAN || m == MON_MAR || m == MON_MAY || m == MON_JUL ||
            m == MON_AUG || m == MON_OCT || m == MON_DEC)
        begin
            len = mlen_t'(31);
        end
        else if (m == MON_FEB)
        begin
            len = leap ? mlen_t'(29) : mlen_t'(28);
        end
        return len;
    endfunction

endpackage

@@ rtl/core/gdd_epoch_unit.sv @@
module gdd_epoch_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  gdd_pkg::year_t  year,
    input  gdd_pkg::month_t month,
    input  gdd_pkg::day_t   day,
    output logic            done,
    output gdd_pkg::epoch_t epoch
);
    import gdd_pkg::*;

    eu_state_t state_reg, state_next;
    year_t     year_reg, year_next;
    month_t    month_reg, month_next;
    day_t      day_reg, day_next;
    quot_t     q_reg, q_next;
    logic      leap_reg, leap_next;
    month_t    mon_reg, mon_next;
    epoch_t    acc_reg, acc_next;

    year_t                prev_year;
    year_t                mul_in;
    logic [PROD_W-1:0]    prod;
    quot_t                quot;
    logic                 cent_zero;
    epoch_t               leaps;
    epoch_t               base;
    logic                 take;

    assign prev_year = year_reg - year_t'(1);

    // Shared reciprocal multiplier: quotient by 100 of the year, then of year - 1
    assign mul_in = (state_reg == EU_QYEAR) ? year_reg : prev_year;
    assign prod   = PROD_W'(mul_in) * PROD_W'(RECIP_100);
    assign quot   = prod[RECIP_SHIFT +: Q_W];

    assign cent_zero = (CENT_W'(q_reg) * CENT_W'(DAYS_PER_CENT)) == CENT_W'(year_reg);

    // Leap days in years 0 .. y-1, with n = y-1: n/4 - n/100 + n/400 + 1
    assign leaps = epoch_t'(prev_year[YEAR_W-1:2]) - epoch_t'(q_reg)
                 + epoch_t'(q_reg[Q_W-1:2]) + epoch_t'(1);
    assign base  = (year_reg == '0) ? '0
                 : epoch_t'(year_reg) * epoch_t'(DAYS_PER_YEAR) + leaps;

    assign epoch = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EU_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        q_reg     <= q_next;
        leap_reg  <= leap_next;
        mon_reg   <= mon_next;
        acc_reg   <= acc_next;
    end

    always_comb
    begin
        state_next = state_reg;
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        q_next     = q_reg;
        leap_next  = leap_reg;
        mon_next   = mon_reg;
        acc_next   = acc_reg;
        done       = 1'b0;
        take       = 1'b0;

        unique case (state_reg)
            EU_IDLE:
            begin
                take = start;
            end
            EU_QYEAR:
            begin
                q_next     = quot;
                acc_next   = epoch_t'(day_reg);
                state_next = EU_QPREV;
            end
            EU_QPREV:
            begin
                leap_next  = (year_reg[1:0] == 2'b00) &&
                             (!cent_zero || (q_reg[1:0] == 2'b00));
                q_next     = quot;
                state_next = EU_BASE;
            end
            EU_BASE:
            begin
                acc_next   = acc_reg + base;
                mon_next   = month_t'(1);
                state_next = EU_MONTH;
            end
            EU_MONTH:
            begin
                if (mon_reg < month_reg)
                begin
                    acc_next = acc_reg + epoch_t'(month_length(mon_reg, leap_reg));
                    mon_next = mon_reg + month_t'(1);
                end
                else
                begin
                    done       = 1'b1;
                    take       = start;
                    state_next = EU_IDLE;
                end
            end
            default:
            begin
                state_next = EU_IDLE;
            end
        endcase

        if (take)
        begin
            year_next  = year;
            month_next = month;
            day_next   = day;
            state_next = EU_QYEAR;
        end
    end

endmodule

@@ rtl/core/gregorian_date_difference_unit.sv @@
// Days between two Gregorian dates. A transfer on the input channel carries
// two dates (year, month, day); one transfer on the output channel later
// returns the absolute number of days between them. Years above MAX_YEAR
// saturate to MAX_YEAR, dates are not checked, and a distance that does not
// fit 22 bits saturates to all ones. Each date becomes a day count from the
// start of year 0 in a shared epoch unit: one reciprocal multiplier finds
// the quotient by 100 for the leap rule, and one accumulator adds the day,
// the days of all earlier years and then one month length per cycle. The
// two dates go through that unit one after the other. in_stall stays high
// from the transfer until the result is loaded into the output register;
// a month code of zero is counted like one. A finished result sits in an
// output register, so the next item may start while it waits.
module gregorian_date_difference_unit #(
    parameter int unsigned MAX_YEAR = gdd_pkg::DEFAULT_MAX_YEAR
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  gdd_pkg::year_t  first_year,
    input  gdd_pkg::month_t first_month,
    input  gdd_pkg::day_t   first_day,
    input  gdd_pkg::year_t  second_year,
    input  gdd_pkg::month_t second_month,
    input  gdd_pkg::day_t   second_day,
    output logic            out_valid,
    input  logic            out_stall,
    output gdd_pkg::dist_t  day_distance
);
    import gdd_pkg::*;

    top_state_t state_reg, state_next;

    // Second date waits here while the first is counted
    year_t  year_b_reg, year_b_next;
    month_t month_b_reg, month_b_next;
    day_t   day_b_reg, day_b_next;

    epoch_t epoch_a_reg, epoch_a_next;
    epoch_t epoch_b_reg, epoch_b_next;

    logic   out_valid_reg, out_valid_next;
    dist_t  dist_reg, dist_next;

    logic   in_xfer;
    logic   out_xfer;
    logic   out_free;
    year_t  first_year_sat;
    year_t  second_year_sat;

    logic   eu_start;
    year_t  eu_year;
    month_t eu_month;
    day_t   eu_day;
    logic   eu_done;
    epoch_t eu_epoch;

    epoch_t diff;

    // Saturate a year to MAX_YEAR; a MAX_YEAR above the year range never bites
    function automatic year_t clamp_year(input year_t y);
        year_t r;
        r = y;
        if (MAX_YEAR_W'(y) > MAX_YEAR_W'(MAX_YEAR))
        begin
            r = YEAR_W'(MAX_YEAR);
        end
        return r;
    endfunction

    assign first_year_sat  = clamp_year(first_year);
    assign second_year_sat = clamp_year(second_year);

    assign in_stall     = (state_reg != ST_IDLE);
    assign in_xfer      = in_valid && !in_stall;
    assign out_valid    = out_valid_reg;
    assign day_distance = dist_reg;
    assign out_xfer     = out_valid_reg && !out_stall;
    // Load the output register when it is empty or being drained this cycle
    assign out_free     = !out_valid_reg || !out_stall;

    // First date goes to the epoch unit straight from the ports at the transfer
    assign eu_year  = (state_reg == ST_IDLE) ? first_year_sat : year_b_reg;
    assign eu_month = (state_reg == ST_IDLE) ? first_month    : month_b_reg;
    assign eu_day   = (state_reg == ST_IDLE) ? first_day      : day_b_reg;

    assign diff = (epoch_a_reg > epoch_b_reg) ? (epoch_a_reg - epoch_b_reg)
                                              : (epoch_b_reg - epoch_a_reg);

    gdd_epoch_unit u_epoch (
        .clk   (clk),
        .rst_n (rst_n),
        .start (eu_start),
        .year  (eu_year),
        .month (eu_month),
        .day   (eu_day),
        .done  (eu_done),
        .epoch (eu_epoch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_b_reg  <= year_b_next;
        month_b_reg <= month_b_next;
        day_b_reg   <= day_b_next;
        epoch_a_reg <= epoch_a_next;
        epoch_b_reg <= epoch_b_next;
        dist_reg    <= dist_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        year_b_next    = year_b_reg;
        month_b_next   = month_b_reg;
        day_b_next     = day_b_reg;
        epoch_a_next   = epoch_a_reg;
        epoch_b_next   = epoch_b_reg;
        dist_next      = dist_reg;
        out_valid_next = out_valid_reg && !out_xfer;
        eu_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Launch the first date and hold the second
                if (in_xfer)
                begin
                    eu_start     = 1'b1;
                    year_b_next  = second_year_sat;
                    month_b_next = second_month;
                    day_b_next   = second_day;
                    state_next   = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (eu_done)
                begin
                    epoch_a_next = eu_epoch;
                    eu_start     = 1'b1;
                    state_next   = ST_SECOND;
                end
            end
            ST_SECOND:
            begin
                if (eu_done)
                begin
                    epoch_b_next = eu_epoch;
                    state_next   = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                // Hold the result until the output register can take it
                if (out_free)
                begin
                    dist_next      = (diff > epoch_t'(DIST_MAX)) ? DIST_MAX
                                                                  : diff[DIST_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/gdd_checker.sv @@
module gdd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input gdd_pkg::dist_t day_distance
);
    import gdd_pkg::*;

    // A transfer in starts work, so the input side closes at once
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a transfer");

    // The input side reopens only as a finished result is presented
    a_reopen_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("input reopened without a result");

    // A new result appears exactly as the block turns idle
    a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result appeared while still busy");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(day_distance)))
        else $error("stalled result changed");

endmodule

bind gregorian_date_difference_unit gdd_checker u_gdd_checker (.*);
